>>> hdl/lru_cache_directory_top_macros.svh
// Assertion macros for the cache directory.
// Clock is clock and reset is reset in every user of these macros.
`ifndef LRU_CACHE_DIRECTORY_TOP_MACROS_SVH
`define LRU_CACHE_DIRECTORY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LCD_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("lcd assertion failed");
`define LCD_ASSERT_NXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("lcd assertion failed");
`else
`define LCD_ASSERT_IMP(lbl, a, b)
`define LCD_ASSERT_NXT(lbl, a, b)
`endif
`endif

>>> hdl/lcd_pkg.sv
`default_nettype none
package lcd_pkg;
   localparam int SMALL_ENTRIES = 16;
   localparam int LARGE_ENTRIES = 32;
   localparam int TIME_BITS     = 32;
   localparam int MAX_ENTRIES   = 64;
   localparam int IDX_W         = $clog2(MAX_ENTRIES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int ADDR_W        = IDX_W + 1;
   localparam int RAM_DEPTH     = 2 * MAX_ENTRIES;
   localparam int TAG_W         = 32;
   localparam int SLOT_W        = 5;
   localparam int POS_W         = 5;

   localparam logic [TAG_W-1:0]     FREE_TAG   = 32'hFFFF_FFFF;
   localparam logic [TAG_W-1:0]     TEMP_TAG   = 32'hFFFF_FFFE;
   localparam logic [TIME_BITS-1:0] TIME_MASK  = {TIME_BITS{1'b1}};
   localparam logic [TIME_BITS-1:0] TIME_LIMIT = TIME_MASK - 1'b1;

   typedef enum logic [2:0] {
      CMD_FIND    = 3'd0,
      CMD_ALLOC   = 3'd1,
      CMD_VICTIM  = 3'd2,
      CMD_DISCARD = 3'd3,
      CMD_SETTAG  = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_SORT_HOLD,
      ST_SORT_CMP,
      ST_SORT_PLACE,
      ST_RENUM,
      ST_SCAN,
      ST_STAMP,
      ST_DISCARD,
      ST_SETTAG
   } state_type;

   function automatic logic [CNT_W-1:0] table_size(input logic t);
      return t ? CNT_W'(LARGE_ENTRIES) : CNT_W'(SMALL_ENTRIES);
   endfunction
endpackage
`default_nettype wire

>>> hdl/lru_cache_directory_top.sv
// Channel     | Direction | Handshake               | Payload
// request     | in        | start high, busy low    | req_cmd, req_table_sel, req_tag, req_position
// response    | out       | rsp_valid, one cycle    | rsp_status, rsp_entry_position,
//             |           |                         | rsp_data_slot, rsp_entry_tag
// One transaction at a time; busy stays high from acceptance until the response is given.
// Find, allocate and victim scan the table of n entries (n = 16 or 32) through one RAM read port.
// Discard frees every entry in turn, set tag writes one entry if in range, unused codes leave busy low;
// each response shows in the first cycle after busy falls.
// When the use counter hits its limit, find and allocate first run an insertion sort through
// the same port, then a renumbering pass over the n entries.
// After reset a clearing pass fills all 128 words of every entry RAM; busy is high meanwhile.
// The receiver cannot stall: each response is shown for exactly one cycle.
`default_nettype none
`include "lru_cache_directory_top_macros.svh"
module lru_cache_directory_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_cmd,
   input  wire logic        req_table_sel,
   input  wire logic [31:0] req_tag,
   input  wire logic [4:0]  req_position,
   output logic             rsp_valid,
   output logic             rsp_status,
   output logic [4:0]       rsp_entry_position,
   output logic [4:0]       rsp_data_slot,
   output logic [31:0]      rsp_entry_tag
);
   localparam int IW = lcd_pkg::IDX_W;
   localparam int CW = lcd_pkg::CNT_W;
   localparam int AW = lcd_pkg::ADDR_W;
   localparam int TW = lcd_pkg::TIME_BITS;

   lcd_pkg::state_type state_ff, state_in;
   lcd_pkg::cmd_type   cmd_ff, cmd_in;
   logic                        tbl_ff, tbl_in;
   logic [lcd_pkg::TAG_W-1:0]   tag_ff, tag_in;
   logic [lcd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [AW-1:0]               init_ff, init_in;
   logic [TW-1:0]               ctr_ff [2];
   logic [TW-1:0]               ctr_in [2];
   logic [CW-1:0]               i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                        pend_ff, pend_in, hit_ff, hit_in;
   logic [IW-1:0]               cidx_ff, cidx_in, hidx_ff, hidx_in;
   logic [lcd_pkg::TAG_W-1:0]   htag_ff, htag_in, hold_tag_ff, hold_tag_in;
   logic [lcd_pkg::SLOT_W-1:0]  hslot_ff, hslot_in, hold_slot_ff, hold_slot_in;
   logic [TW-1:0]               oldest_ff, oldest_in, hold_time_ff, hold_time_in;
   logic                        rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic [4:0]                  rsp_pos_ff, rsp_pos_in, rsp_slot_ff, rsp_slot_in;
   logic [31:0]                 rsp_tag_ff, rsp_tag_in;

   logic                        accept;
   logic [CW-1:0]               n_w;
   logic [TW-1:0]               cur_ctr;
   logic [IW-1:0]               rd_idx, wr_idx;
   logic [AW-1:0]               rd_addr, wr_addr;
   logic                        we_tag, we_time, we_slot;
   logic [lcd_pkg::TAG_W-1:0]   wd_tag, rd_tag;
   logic [TW-1:0]               wd_time, rd_time;
   logic [lcd_pkg::SLOT_W-1:0]  wd_slot, rd_slot;
   logic                        use_init;

   assign accept  = start && !busy;
   assign busy    = (state_ff != lcd_pkg::ST_IDLE);
   assign n_w     = lcd_pkg::table_size(tbl_ff);
   assign cur_ctr = ctr_ff[tbl_ff];
   assign use_init = (state_ff == lcd_pkg::ST_INIT);
   assign rd_addr = {tbl_ff, rd_idx};
   assign wr_addr = use_init ? init_ff : {tbl_ff, wr_idx};

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_data_slot      = rsp_slot_ff;
   assign rsp_entry_tag      = rsp_tag_ff;

   lcd_ram #(.WIDTH(lcd_pkg::TAG_W), .DEPTH(lcd_pkg::RAM_DEPTH)) u_tag_ram (
      .clock(clock), .wr_en(we_tag), .wr_addr(wr_addr), .wr_data(wd_tag),
      .rd_addr(rd_addr), .rd_data(rd_tag)
   );
   lcd_ram #(.WIDTH(TW), .DEPTH(lcd_pkg::RAM_DEPTH)) u_time_ram (
      .clock(clock), .wr_en(we_time), .wr_addr(wr_addr), .wr_data(wd_time),
      .rd_addr(rd_addr), .rd_data(rd_time)
   );
   lcd_ram #(.WIDTH(lcd_pkg::SLOT_W), .DEPTH(lcd_pkg::RAM_DEPTH)) u_slot_ram (
      .clock(clock), .wr_en(we_slot), .wr_addr(wr_addr), .wr_data(wd_slot),
      .rd_addr(rd_addr), .rd_data(rd_slot)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcd_pkg::ST_INIT: begin
            if (init_ff == {AW{1'b1}}) state_in = lcd_pkg::ST_IDLE;
         end
         lcd_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (lcd_pkg::cmd_type'(req_cmd))
                  lcd_pkg::CMD_FIND, lcd_pkg::CMD_ALLOC: state_in = lcd_pkg::ST_CHECK;
                  lcd_pkg::CMD_VICTIM:  state_in = lcd_pkg::ST_SCAN;
                  lcd_pkg::CMD_DISCARD: state_in = lcd_pkg::ST_DISCARD;
                  lcd_pkg::CMD_SETTAG:  state_in = lcd_pkg::ST_SETTAG;
                  default:              state_in = lcd_pkg::ST_IDLE;
               endcase
            end
         end
         lcd_pkg::ST_CHECK: begin
            state_in = (cur_ctr >= lcd_pkg::TIME_LIMIT) ? lcd_pkg::ST_SORT_HOLD
                                                        : lcd_pkg::ST_SCAN;
         end
         lcd_pkg::ST_SORT_HOLD: state_in = lcd_pkg::ST_SORT_CMP;
         lcd_pkg::ST_SORT_CMP: begin
            if (rd_time > hold_time_ff) begin
               if (j_ff == CW'(1)) state_in = lcd_pkg::ST_SORT_PLACE;
            end else begin
               state_in = (i_ff + 1'b1 == n_w) ? lcd_pkg::ST_RENUM : lcd_pkg::ST_SORT_HOLD;
            end
         end
         lcd_pkg::ST_SORT_PLACE: begin
            state_in = (i_ff + 1'b1 == n_w) ? lcd_pkg::ST_RENUM : lcd_pkg::ST_SORT_HOLD;
         end
         lcd_pkg::ST_RENUM: begin
            if (k_ff == n_w - 1'b1) state_in = lcd_pkg::ST_SCAN;
         end
         lcd_pkg::ST_SCAN: begin
            if (pend_ff && ((cmd_ff == lcd_pkg::CMD_FIND && rd_tag == tag_ff) ||
                            rd_tag == lcd_pkg::FREE_TAG && cmd_ff != lcd_pkg::CMD_FIND)) begin
               state_in = lcd_pkg::ST_STAMP;
            end else if (!pend_ff && k_ff == n_w) begin
               state_in = (cmd_ff == lcd_pkg::CMD_VICTIM && hit_ff) ? lcd_pkg::ST_STAMP
                                                                     : lcd_pkg::ST_IDLE;
            end
         end
         lcd_pkg::ST_STAMP:   state_in = lcd_pkg::ST_IDLE;
         lcd_pkg::ST_DISCARD: begin
            if (k_ff == n_w - 1'b1) state_in = lcd_pkg::ST_IDLE;
         end
         lcd_pkg::ST_SETTAG:  state_in = lcd_pkg::ST_IDLE;
         default:             state_in = lcd_pkg::ST_IDLE;
      endcase
   end

   // Datapath, RAM control and response
   always_comb begin
      cmd_in = cmd_ff; tbl_in = tbl_ff; tag_in = tag_ff; pos_in = pos_ff;
      init_in = init_ff;
      ctr_in[0] = ctr_ff[0]; ctr_in[1] = ctr_ff[1];
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      pend_in = pend_ff; hit_in = hit_ff; cidx_in = cidx_ff; hidx_in = hidx_ff;
      htag_in = htag_ff; hslot_in = hslot_ff; oldest_in = oldest_ff;
      hold_tag_in = hold_tag_ff; hold_time_in = hold_time_ff; hold_slot_in = hold_slot_ff;
      rsp_valid_in = 1'b0; rsp_status_in = 1'b1;
      rsp_pos_in = '0; rsp_slot_in = '0; rsp_tag_in = '0;
      rd_idx = '0; wr_idx = '0;
      we_tag = 1'b0; we_time = 1'b0; we_slot = 1'b0;
      wd_tag = rd_tag; wd_time = rd_time; wd_slot = rd_slot;

      unique case (state_ff)
         lcd_pkg::ST_INIT: begin
            we_tag = 1'b1; we_time = 1'b1; we_slot = 1'b1;
            wd_tag = lcd_pkg::FREE_TAG; wd_time = '0;
            wd_slot = init_ff[lcd_pkg::SLOT_W-1:0];
            init_in = init_ff + 1'b1;
         end
         lcd_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in = lcd_pkg::cmd_type'(req_cmd);
               tbl_in = req_table_sel; tag_in = req_tag; pos_in = req_position;
               k_in = '0;
               unique case (lcd_pkg::cmd_type'(req_cmd))
                  lcd_pkg::CMD_FIND, lcd_pkg::CMD_ALLOC, lcd_pkg::CMD_VICTIM,
                  lcd_pkg::CMD_DISCARD, lcd_pkg::CMD_SETTAG: ;
                  default: rsp_valid_in = 1'b1;   // drop unused codes
               endcase
            end
         end
         lcd_pkg::ST_CHECK: begin
            rd_idx = IW'(1);
            i_in = CW'(1);
         end
         lcd_pkg::ST_SORT_HOLD: begin
            hold_tag_in = rd_tag; hold_time_in = rd_time; hold_slot_in = rd_slot;
            j_in = i_ff;
            rd_idx = IW'(i_ff - 1'b1);
         end
         lcd_pkg::ST_SORT_CMP: begin
            we_tag = 1'b1; we_time = 1'b1; we_slot = 1'b1;
            wr_idx = j_ff[IW-1:0];
            if (rd_time > hold_time_ff) begin
               j_in = j_ff - 1'b1;
               rd_idx = IW'(j_ff - CW'(2));
            end else begin
               wd_tag = hold_tag_ff; wd_time = hold_time_ff; wd_slot = hold_slot_ff;
               i_in = i_ff + 1'b1;
               rd_idx = IW'(i_ff + 1'b1);
               k_in = '0;
            end
         end
         lcd_pkg::ST_SORT_PLACE: begin
            we_tag = 1'b1; we_time = 1'b1; we_slot = 1'b1;
            wr_idx = j_ff[IW-1:0];
            wd_tag = hold_tag_ff; wd_time = hold_time_ff; wd_slot = hold_slot_ff;
            i_in = i_ff + 1'b1;
            rd_idx = IW'(i_ff + 1'b1);
            k_in = '0;
         end
         lcd_pkg::ST_RENUM: begin
            we_time = 1'b1;
            wr_idx = k_ff[IW-1:0];
            wd_time = TW'(k_ff);
            k_in = k_ff + 1'b1;
            if (k_ff == n_w - 1'b1) ctr_in[tbl_ff] = TW'(n_w);
         end
         lcd_pkg::ST_SCAN: begin
            rd_idx = k_ff[IW-1:0];
            if (k_ff < n_w) begin
               k_in = k_ff + 1'b1; pend_in = 1'b1; cidx_in = k_ff[IW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if ((cmd_ff == lcd_pkg::CMD_FIND && rd_tag == tag_ff) ||
                   (cmd_ff != lcd_pkg::CMD_FIND && rd_tag == lcd_pkg::FREE_TAG) ||
                   (cmd_ff == lcd_pkg::CMD_VICTIM && rd_time < oldest_ff)) begin
                  hit_in = 1'b1; hidx_in = cidx_ff; htag_in = rd_tag; hslot_in = rd_slot;
                  oldest_in = rd_time;
               end
            end else if (k_ff == n_w && !(cmd_ff == lcd_pkg::CMD_VICTIM && hit_ff)) begin
               rsp_valid_in = 1'b1;   // miss or full table
            end
         end
         lcd_pkg::ST_STAMP: begin
            we_time = 1'b1;
            wr_idx = hidx_ff;
            wd_time = cur_ctr;
            we_tag = (cmd_ff == lcd_pkg::CMD_ALLOC);
            wd_tag = lcd_pkg::TEMP_TAG;
            ctr_in[tbl_ff] = cur_ctr + 1'b1;
            rsp_valid_in = 1'b1; rsp_status_in = 1'b0;
            rsp_pos_in = hidx_ff[4:0]; rsp_slot_in = hslot_ff;
            rsp_tag_in = (cmd_ff == lcd_pkg::CMD_ALLOC) ? lcd_pkg::TEMP_TAG : htag_ff;
         end
         lcd_pkg::ST_DISCARD: begin
            we_tag = 1'b1;
            wr_idx = k_ff[IW-1:0];
            wd_tag = lcd_pkg::FREE_TAG;
            k_in = k_ff + 1'b1;
            if (k_ff == n_w - 1'b1) begin
               ctr_in[tbl_ff] = '0;
               rsp_valid_in = 1'b1;
            end
         end
         lcd_pkg::ST_SETTAG: begin
            we_tag = (CW'(pos_ff) < n_w);
            wr_idx = IW'(pos_ff);
            wd_tag = tag_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase

      // Arm the scan registers on entry
      if (state_in == lcd_pkg::ST_SCAN && state_ff != lcd_pkg::ST_SCAN) begin
         k_in = '0; pend_in = 1'b0; hit_in = 1'b0; oldest_in = lcd_pkg::TIME_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcd_pkg::ST_INIT;
         init_ff      <= '0;
         ctr_ff[0]    <= '0;
         ctr_ff[1]    <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         ctr_ff[0]    <= ctr_in[0];
         ctr_ff[1]    <= ctr_in[1];
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; tbl_ff <= tbl_in; tag_ff <= tag_in; pos_ff <= pos_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      cidx_ff <= cidx_in; hidx_ff <= hidx_in; htag_ff <= htag_in; hslot_ff <= hslot_in;
      oldest_ff <= oldest_in;
      hold_tag_ff <= hold_tag_in; hold_time_ff <= hold_time_in; hold_slot_ff <= hold_slot_in;
      rsp_status_ff <= rsp_status_in; rsp_pos_ff <= rsp_pos_in;
      rsp_slot_ff <= rsp_slot_in; rsp_tag_ff <= rsp_tag_in;
   end

   `LCD_ASSERT_NXT(a_stamp_hits, state_ff == lcd_pkg::ST_STAMP, rsp_valid && !rsp_status)
   `LCD_ASSERT_IMP(a_miss_zero, rsp_valid && rsp_status, rsp_entry_tag == '0 && rsp_entry_position == '0)
   `LCD_ASSERT_IMP(a_sort_j, state_ff == lcd_pkg::ST_SORT_CMP, j_ff != '0)
endmodule
`default_nettype wire

>>> hdl/lcd_ram.sv
`default_nettype none
module lcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire
